### hdl/cslb_pkg.sv
`default_nettype none
package cslb_pkg;

    localparam int PW_W     = 24;
    localparam int ST_W     = 20;
    localparam int CC_W     = 5;
    localparam int WL_W     = 40;
    localparam int CW_W     = 41;
    localparam int CI_W     = 4;
    localparam int CFG_IX_W = 1;

    localparam int MAX_CORES_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [CW_W-1:0] CW_MAX = {CW_W{1'b1}};

    localparam logic [CFG_IX_W-1:0] REG_CORE_COUNT   = 1'd0;
    localparam logic [CFG_IX_W-1:0] REG_WEIGHT_LIMIT = 1'd1;

    typedef struct packed {
        logic            job_start;
        logic [ST_W-1:0] site_total;
        logic [PW_W-1:0] partition_weight;
    } item_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } math_op_t;

    typedef struct packed {
        logic     start;
        math_op_t op;
    } math_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_DIVW,
        ST_RD,
        ST_WCMP,
        ST_WMUL,
        ST_SMUL,
        ST_SMW,
        ST_SDW,
        ST_SNM,
        ST_UPD,
        ST_EMIT
    } eng_state_t;

endpackage
`default_nettype wire

### hdl/cslb_front.sv
`default_nettype none
module cslb_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [cslb_pkg::PW_W-1:0]     partition_weight,
    input  wire [cslb_pkg::ST_W-1:0]     site_total,
    input  wire                          job_start,
    output logic                         q_valid,
    input  wire                          q_pop,
    output cslb_pkg::item_t              q_item
);
    import cslb_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{job_start: job_start, site_total: site_total,
                                     partition_weight: partition_weight};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

### hdl/cslb_math.sv
`default_nettype none
module cslb_math #(
    parameter int N  = 42,
    parameter int MW = 20
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  cslb_pkg::math_ctl_t    ctl,
    input  wire [N-1:0]            a,
    input  wire [N-1:0]            b,
    output logic                   done,
    output logic [N-1:0]           result
);
    import cslb_pkg::*;

    localparam int CNW = $clog2(N + 1);

    logic           busy_reg;
    logic           done_reg;
    math_op_t       op_reg;
    logic [CNW-1:0] cnt_reg;
    logic [N-1:0]   rem_reg;
    logic [N-1:0]   quo_reg;
    logic [N-1:0]   dvs_reg;
    logic [N-1:0]   acc_reg;
    logic [MW-1:0]  mpl_reg;
    logic [N:0]     tr;
    logic           ge;

    assign tr     = {rem_reg, quo_reg[N-1]};
    assign ge     = (tr >= {1'b0, dvs_reg});
    assign done   = done_reg;
    assign result = (op_reg == OP_DIV) ? quo_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
                if ((op_reg == OP_DIV && cnt_reg == CNW'(N - 1)) ||
                    (op_reg == OP_MUL && cnt_reg == CNW'(MW - 1)))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= a;
            dvs_reg <= b;
            acc_reg <= '0;
            mpl_reg <= a[MW-1:0];
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                rem_reg <= ge ? N'(tr - {1'b0, dvs_reg}) : tr[N-1:0];
                quo_reg <= {quo_reg[N-2:0], ge};
            end
            else
            begin
                if (mpl_reg[0])
                    acc_reg <= acc_reg + dvs_reg;
                dvs_reg <= {dvs_reg[N-2:0], 1'b0};
                mpl_reg <= {1'b0, mpl_reg[MW-1:1]};
            end
        end
    end

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("math done without a running operation");

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) ctl.start |-> !busy_reg;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy)
        else $error("math started while busy");

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg;
    endproperty
    a_done_pulse: assert property (p_done_pulse)
        else $error("math done longer than one cycle");

endmodule
`default_nettype wire

### hdl/cslb_engine.sv
`default_nettype none
module cslb_engine #(
    parameter int MAX_CORES = 16,
    parameter int FRAC_BITS = 16,
    parameter int N         = 42
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [cslb_pkg::CC_W-1:0]     core_count,
    input  wire [cslb_pkg::WL_W-1:0]     weight_limit,
    input  wire                          q_valid,
    output logic                         q_pop,
    input  cslb_pkg::item_t              q_item,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [cslb_pkg::CI_W-1:0]    core_index,
    output logic [cslb_pkg::ST_W-1:0]    site_start,
    output logic [cslb_pkg::ST_W-1:0]    site_count,
    output logic                         last
);
    import cslb_pkg::*;

    localparam int CIX = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int XW  = 8;
    localparam int KW  = $clog2(MAX_CORES + 2);

    eng_state_t      state_reg, state_next;
    logic [PW_W-1:0] pw_reg, pw_next;
    logic [ST_W-1:0] sites_reg, sites_next;
    logic [CIX-1:0]  cur_reg, cur_next;
    logic            split_reg, split_next;
    logic [N-1:0]    p_reg, p_next;
    logic [ST_W-1:0] offset_reg, offset_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [ST_W-1:0] n_reg, n_next;
    logic [N-1:0]    addw_reg, addw_next;
    logic [N-1:0]    remw_reg, remw_next;
    logic            ff_reg, ff_next;
    logic            adv_reg, adv_next;

    logic [MAX_CORES-1:0] vld_reg;
    logic [MAX_CORES-1:0] full_reg;
    logic [CW_W-1:0]      cw_mem [MAX_CORES];
    logic [CW_W-1:0]      cw_q;
    logic                 vq_q;
    logic [CW_W-1:0]      cw_cur;

    logic            out_valid_reg;
    logic [CI_W-1:0] core_index_reg;
    logic [ST_W-1:0] site_start_reg;
    logic [ST_W-1:0] site_count_reg;
    logic            last_reg;

    logic            clear_job;
    logic            mem_we;
    logic            out_load;
    math_ctl_t       mctl;
    logic [N-1:0]    ma, mb;
    logic            m_done;
    logic [N-1:0]    m_res;

    logic [XW-1:0]   cores;
    logic [CIX-1:0]  cur_inc;
    logic [N-1:0]    total;
    logic [ST_W-1:0] remaining;
    logic [41:0]     free_w;
    logic            free_pos;
    logic [N-1:0]    free_ext;
    logic [N:0]      wsum;
    logic [N:0]      csum;
    logic [CW_W-1:0] cw_sat;
    logic [ST_W:0]   end_pos;

    cslb_math #(
        .N  (N),
        .MW (ST_W)
    ) u_math (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mctl),
        .a      (ma),
        .b      (mb),
        .done   (m_done),
        .result (m_res)
    );

    always_comb
    begin
        if (core_count == '0)
            cores = XW'(1);
        else if (XW'(core_count) > XW'(MAX_CORES))
            cores = XW'(MAX_CORES);
        else
            cores = XW'(core_count);
    end

    assign cur_inc   = (XW'(cur_reg) + XW'(1) == cores) ? '0 : CIX'(cur_reg + CIX'(1));
    assign cw_cur    = vq_q ? cw_q : '0;
    assign total     = N'(pw_reg) << FRAC_BITS;
    assign remaining = sites_reg - offset_reg;
    assign free_w    = {2'b00, weight_limit} - {1'b0, cw_cur};
    assign free_pos  = !free_w[41] && (free_w != '0);
    assign free_ext  = N'(free_w[40:0]);
    assign wsum      = (N + 1)'(total) + (N + 1)'(cw_cur);
    assign csum      = (N + 1)'(cw_cur) + (N + 1)'(addw_reg);
    assign cw_sat    = (csum > (N + 1)'(CW_MAX)) ? CW_MAX : csum[CW_W-1:0];
    assign end_pos   = {1'b0, offset_reg} + {1'b0, n_reg};

    always_comb
    begin
        state_next  = state_reg;
        pw_next     = pw_reg;
        sites_next  = sites_reg;
        cur_next    = cur_reg;
        split_next  = split_reg;
        p_next      = p_reg;
        offset_next = offset_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        addw_next   = addw_reg;
        remw_next   = remw_reg;
        ff_next     = ff_reg;
        adv_next    = adv_reg;
        q_pop       = 1'b0;
        clear_job   = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        mctl        = '{start: 1'b0, op: OP_MUL};
        ma          = '0;
        mb          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    pw_next    = q_item.partition_weight;
                    sites_next = q_item.site_total;
                    if (q_item.job_start)
                    begin
                        clear_job  = 1'b1;
                        cur_next   = '0;
                        split_next = 1'b0;
                    end
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (sites_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    if (XW'(cur_reg) >= cores)
                        cur_next = '0;
                    mctl       = '{start: 1'b1, op: OP_DIV};
                    ma         = total;
                    mb         = N'(sites_reg);
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (m_done)
                begin
                    p_next      = m_res;
                    offset_next = '0;
                    k_next      = '0;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = split_reg ? ST_SMUL : ST_WCMP;
            end
            ST_WCMP:
            begin
                if (wsum > (N + 1)'(weight_limit))
                begin
                    split_next = 1'b1;
                    state_next = ST_SMUL;
                end
                else
                begin
                    mctl       = '{start: 1'b1, op: OP_MUL};
                    ma         = N'(sites_reg);
                    mb         = p_reg;
                    state_next = ST_WMUL;
                end
            end
            ST_WMUL:
            begin
                if (m_done)
                begin
                    addw_next  = m_res;
                    n_next     = sites_reg;
                    ff_next    = 1'b0;
                    state_next = ST_UPD;
                end
            end
            ST_SMUL:
            begin
                mctl       = '{start: 1'b1, op: OP_MUL};
                ma         = N'(remaining);
                mb         = p_reg;
                state_next = ST_SMW;
            end
            ST_SMW:
            begin
                if (m_done)
                begin
                    remw_next = m_res;
                    n_next    = remaining;
                    addw_next = m_res;
                    if (free_pos && (m_res < free_ext))
                    begin
                        ff_next    = 1'b0;
                        state_next = ST_UPD;
                    end
                    else if (!free_pos || p_reg == '0)
                    begin
                        ff_next    = 1'b1;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        ff_next    = 1'b1;
                        mctl       = '{start: 1'b1, op: OP_DIV};
                        ma         = free_ext + p_reg - N'(1);
                        mb         = p_reg;
                        state_next = ST_SDW;
                    end
                end
            end
            ST_SDW:
            begin
                if (m_done)
                begin
                    if (m_res >= N'(remaining))
                    begin
                        n_next     = remaining;
                        addw_next  = remw_reg;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        n_next     = m_res[ST_W-1:0];
                        mctl       = '{start: 1'b1, op: OP_MUL};
                        ma         = m_res;
                        mb         = p_reg;
                        state_next = ST_SNM;
                    end
                end
            end
            ST_SNM:
            begin
                if (m_done)
                begin
                    addw_next  = m_res;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                mem_we     = 1'b1;
                adv_next   = !split_reg || ff_reg || full_reg[cur_reg];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load    = 1'b1;
                    offset_next = end_pos[ST_W-1:0];
                    k_next      = k_reg + KW'(1);
                    if (adv_reg)
                        cur_next = cur_inc;
                    if (split_reg && (end_pos < {1'b0, sites_reg}) &&
                        ((k_reg + KW'(1)) < KW'(MAX_CORES + 1)))
                        state_next = ST_RD;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            split_reg     <= 1'b0;
            vld_reg       <= '0;
            full_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            split_reg <= split_next;
            k_reg     <= k_next;
            if (clear_job)
            begin
                vld_reg  <= '0;
                full_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[cur_reg] <= 1'b1;
                if (ff_reg)
                    full_reg[cur_reg] <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg     <= pw_next;
        sites_reg  <= sites_next;
        p_reg      <= p_next;
        offset_reg <= offset_next;
        n_reg      <= n_next;
        addw_reg   <= addw_next;
        remw_reg   <= remw_next;
        ff_reg     <= ff_next;
        adv_reg    <= adv_next;
        if (out_load)
        begin
            core_index_reg <= CI_W'(cur_reg);
            site_start_reg <= offset_reg;
            site_count_reg <= n_reg;
            last_reg       <= (end_pos >= {1'b0, sites_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cw_mem[cur_reg] <= cw_sat;
        cw_q <= cw_mem[cur_reg];
        vq_q <= vld_reg[cur_reg];
    end

    assign out_valid  = out_valid_reg;
    assign core_index = core_index_reg;
    assign site_start = site_start_reg;
    assign site_count = site_count_reg;
    assign last       = last_reg;

    property p_emit_nonzero;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_EMIT) |-> (n_reg != '0);
    endproperty
    a_emit_nonzero: assert property (p_emit_nonzero)
        else $error("empty run of sites");

    property p_emit_in_range;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_EMIT) |-> (end_pos <= {1'b0, sites_reg});
    endproperty
    a_emit_in_range: assert property (p_emit_in_range)
        else $error("run extends beyond partition");

    property p_split_sticky;
        @(posedge clk) disable iff (!rst_n) $fell(split_reg) |-> $past(clear_job);
    endproperty
    a_split_sticky: assert property (p_split_sticky)
        else $error("split phase left without job start");

    property p_done_when_waiting;
        @(posedge clk) disable iff (!rst_n)
            m_done |-> (state_reg == ST_DIVW || state_reg == ST_WMUL ||
                        state_reg == ST_SMW || state_reg == ST_SDW || state_reg == ST_SNM);
    endproperty
    a_done_when_waiting: assert property (p_done_when_waiting)
        else $error("math result arrived while not waiting");

endmodule
`default_nettype wire

### hdl/cyclic_split_load_balancer_core.sv
// Sequence: a per-site division (N = max(24+FRAC_BITS, 41) + 1,
//   42 at defaults), then per result: whole phase, a weight multiply; split phase, a multiply,
//   plus a division for the fill count and a further multiply when it falls short of the remainder.
// Partitions are worked one at a time through the shared div/mul unit; the input queue
//   in front takes new partitions while one is being worked.
// Reset: asynchronous, active low; clears queue, phase, pointer, core weights and full marks.
`default_nettype none
module cyclic_split_load_balancer_core #(
    parameter int MAX_CORES = cslb_pkg::MAX_CORES_DEF,
    parameter int FRAC_BITS = cslb_pkg::FRAC_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [cslb_pkg::CFG_IX_W-1:0]     cfg_index,
    input  wire [cslb_pkg::WL_W-1:0]         cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [cslb_pkg::PW_W-1:0]         partition_weight,
    input  wire [cslb_pkg::ST_W-1:0]         site_total,
    input  wire                              job_start,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [cslb_pkg::CI_W-1:0]        core_index,
    output logic [cslb_pkg::ST_W-1:0]        site_start,
    output logic [cslb_pkg::ST_W-1:0]        site_count,
    output logic                             last
);
    import cslb_pkg::*;

    localparam int TW = PW_W + FRAC_BITS;
    localparam int N  = ((TW > CW_W) ? TW : CW_W) + 1;

    logic [CC_W-1:0] core_count_reg;
    logic [WL_W-1:0] weight_limit_reg;
    logic            q_valid;
    logic            q_pop;
    item_t           q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_count_reg   <= CC_W'(1);
            weight_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CORE_COUNT:   core_count_reg   <= cfg_data[CC_W-1:0];
                REG_WEIGHT_LIMIT: weight_limit_reg <= cfg_data;
                default:          core_count_reg   <= core_count_reg;
            endcase
        end
    end

    cslb_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .partition_weight (partition_weight),
        .site_total       (site_total),
        .job_start        (job_start),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item)
    );

    cslb_engine #(
        .MAX_CORES (MAX_CORES),
        .FRAC_BITS (FRAC_BITS),
        .N         (N)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .core_count   (core_count_reg),
        .weight_limit (weight_limit_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .core_index   (core_index),
        .site_start   (site_start),
        .site_count   (site_count),
        .last         (last)
    );

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cslb_pkg::*;

    typedef struct packed {
        logic [CI_W-1:0] core;
        logic [ST_W-1:0] start;
        logic [ST_W-1:0] count;
        logic            last;
    } placement_t;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IX_W-1:0] cfg_index;
    logic [WL_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [PW_W-1:0] partition_weight;
    logic [ST_W-1:0] site_total;
    logic job_start;
    logic out_valid;
    logic out_stall;
    logic [CI_W-1:0] core_index;
    logic [ST_W-1:0] site_start;
    logic [ST_W-1:0] site_count;
    logic last;

    item_t partition_q[$];
    placement_t placement_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int idle_cycles;
    int n_partitions;
    int n_placements;
    int n_splits;

    // balancer shadow state
    logic [CC_W-1:0] sh_cores;
    longint unsigned sh_limit;
    longint unsigned sh_weight[MAX_CORES_DEF];
    bit sh_full[MAX_CORES_DEF];
    int sh_cur;
    bit sh_split;

    cyclic_split_load_balancer_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .partition_weight(partition_weight),
        .site_total(site_total),
        .job_start(job_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .core_index(core_index),
        .site_start(site_start),
        .site_count(site_count),
        .last(last)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void clear_job_state();
        for (int i = 0; i < MAX_CORES_DEF; i++)
        begin
            sh_weight[i] = 0;
            sh_full[i] = 0;
        end
        sh_cur = 0;
        sh_split = 0;
    endfunction

    function automatic void charge_core(int c, longint unsigned w);
        longint unsigned s;
        s = sh_weight[c] + w;
        sh_weight[c] = (s > longint'(CW_MAX)) ? longint'(CW_MAX) : s;
    endfunction

    function automatic void assign_partition(item_t it);
        int cores;
        int k;
        longint unsigned total;
        longint unsigned per_site;
        longint unsigned sites;
        longint unsigned offset;
        longint unsigned remaining;
        longint unsigned n;
        longint free_w;
        placement_t p;
        cores = (sh_cores == 0) ? 1 : (sh_cores > MAX_CORES_DEF) ? MAX_CORES_DEF : sh_cores;
        if (it.job_start)
            clear_job_state();
        sites = 64'(it.site_total);
        if (sites == 0)
            return;
        if (sh_cur >= cores)
            sh_cur = 0;
        total = longint'(it.partition_weight) << FRAC_BITS_DEF;
        per_site = total / sites;
        if (!sh_split)
        begin
            if (total + sh_weight[sh_cur] > sh_limit)
                sh_split = 1;
            else
            begin
                charge_core(sh_cur, sites * per_site);
                p.core = CI_W'(sh_cur);
                p.start = '0;
                p.count = ST_W'(sites);
                p.last = 1'b1;
                placement_q = {placement_q, p};
                sh_cur = (sh_cur + 1) % cores;
                return;
            end
        end
        offset = 0;
        k = 0;
        while (offset < sites && k < MAX_CORES_DEF + 1)
        begin
            remaining = sites - offset;
            free_w = longint'(sh_limit) - longint'(sh_weight[sh_cur]);
            if (free_w > 0 && remaining * per_site < longint'(free_w))
                n = remaining;
            else
            begin
                if (free_w <= 0 || per_site == 0)
                    n = remaining;
                else
                begin
                    n = (longint'(free_w) + per_site - 1) / per_site;
                    if (n > remaining)
                        n = remaining;
                end
                sh_full[sh_cur] = 1;
            end
            charge_core(sh_cur, n * per_site);
            p.core = CI_W'(sh_cur);
            p.start = ST_W'(offset);
            p.count = ST_W'(n);
            p.last = (offset + n >= sites);
            placement_q = {placement_q, p};
            k++;
            offset += n;
            if (sh_full[sh_cur])
                sh_cur = (sh_cur + 1) % cores;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            partition_weight <= '0;
            site_total <= '0;
            job_start <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (!in_valid || !in_stall)
            begin
                if (partition_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_t it;
                    it = partition_q.pop_front();
                    in_valid <= 1'b1;
                    partition_weight <= it.partition_weight;
                    site_total <= it.site_total;
                    job_start <= it.job_start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CORE_COUNT)
                    sh_cores = cfg_data[CC_W-1:0];
                else
                    sh_limit = 64'(cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                item_t it;
                it.partition_weight = partition_weight;
                it.site_total = site_total;
                it.job_start = job_start;
                assign_partition(it);
                n_partitions++;
            end
            if (out_valid && !out_stall)
            begin
                placement_t e;
                n_placements++;
                if (placement_q.size() == 0)
                begin
                    $error("unexpected transaction core=%0d start=%0d count=%0d",
                           core_index, site_start, site_count);
                    errors++;
                end
                else
                begin
                    e = placement_q.pop_front();
                    if (!e.last || e.start != 0)
                        n_splits++;
                    if (core_index !== e.core)
                    begin
                        $error("core_index exp %0d got %0d", e.core, core_index);
                        errors++;
                    end
                    if (site_start !== e.start)
                    begin
                        $error("site_start exp %0d got %0d", e.start, site_start);
                        errors++;
                    end
                    if (site_count !== e.count)
                    begin
                        $error("site_count exp %0d got %0d", e.count, site_count);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, last);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [WL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (partition_q.size() > 0 || in_valid || placement_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic add_partition(input int pw, input int st, input bit js);
        item_t it;
        it.partition_weight = PW_W'(pw);
        it.site_total = ST_W'(st);
        it.job_start = js;
        partition_q = {partition_q, it};
    endtask

    task automatic add_job(input int base);
        int n;
        int w[$];
        int st;
        int r;
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++)
            w = {w, int'($urandom_range(99) < 8 ? $urandom_range(1, 24'hFFFFFF)
                                                : $urandom_range(1, 3 * base))};
        w.rsort();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 80)
                st = $urandom_range(1, 40);
            else if (r < 95)
                st = $urandom_range(1, 4095);
            else
                st = $urandom_range(0, 20'hFFFFF);
            add_partition(w[i], st, (i == 0) ? ($urandom_range(9) != 0) : 1'b0);
        end
    endtask

    initial
    begin
        int base;
        int cores;
        longint unsigned lim;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        idle_cycles = 0;
        n_partitions = 0;
        n_placements = 0;
        n_splits = 0;
        sh_cores = 1;
        sh_limit = 0;
        clear_job_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: zero limit, every partition with sites goes to the split path
        add_partition(24'hFFFFFF, 20'hFFFFF, 1'b1);
        add_partition(1, 0, 1'b0);
        add_partition(1, 1, 1'b0);
        add_partition(1, 20'hFFFFF, 1'b0);
        drain();
        write_reg(REG_CORE_COUNT, WL_W'(16));
        write_reg(REG_WEIGHT_LIMIT, 40'hFF_FFFF_FFFF);
        add_partition(24'hFFFFFF, 1, 1'b1);
        add_partition(24'hFFFFFF, 20'hFFFFF, 1'b0);
        add_partition(24'hFFFFFF, 3, 1'b0);
        add_partition(24'h800000, 7, 1'b0);
        add_partition(5, 0, 1'b1);
        drain();
        write_reg(REG_CORE_COUNT, WL_W'(31));
        write_reg(REG_WEIGHT_LIMIT, 40'h3_0000);
        add_partition(2, 4, 1'b1);
        add_partition(2, 4, 1'b0);
        add_partition(2, 3, 1'b0);
        add_partition(7, 5, 1'b0);
        add_partition(1, 20'hFFFFF, 1'b0);
        add_partition(9, 9, 1'b0);
        drain();
        write_reg(REG_CORE_COUNT, WL_W'(3));
        add_partition(40, 17, 1'b0);
        add_partition(1, 2, 1'b0);
        drain();
        write_reg(REG_CORE_COUNT, WL_W'(0));
        write_reg(REG_WEIGHT_LIMIT, 40'h1_8000);
        add_partition(1, 3, 1'b1);
        add_partition(3, 2, 1'b0);
        add_partition(1, 1, 1'b0);
        drain();

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            cores = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            base = $urandom_range(1, 2000);
            lim = (longint'(base) * $urandom_range(1, 6)) << FRAC_BITS_DEF;
            lim = lim + $urandom_range(0, 16'hFFFF);
            if (seg == 7)
                lim = {$urandom, $urandom} & 40'hFF_FFFF_FFFF;
            write_reg(REG_CORE_COUNT, WL_W'(cores));
            write_reg(REG_WEIGHT_LIMIT, WL_W'(lim));
            while (partition_q.size() < 22)
                add_job(base);
            // sender holds off here until all placements are back
            drain();
            write_reg(REG_CORE_COUNT, WL_W'($urandom_range(1, 16)));
            while (partition_q.size() < 22)
                add_job(base);
            drain();
        end

        $display("partitions sent: %0d, placements checked: %0d (%0d from split runs)",
                 n_partitions, n_placements, n_splits);
        $display("core counts 0..31 incl. out-of-range, limits from zero to full scale");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hdl/cslb_pkg.sv
hdl/cslb_front.sv
hdl/cslb_math.sv
hdl/cslb_engine.sv
hdl/cyclic_split_load_balancer_core.sv
verif/tb_top.sv
